// File: rtl/gba_pkg.sv
// Shared types and constants of the grouped bitmap block allocator.
package gba_pkg;

  localparam int NUM_GROUPS_DEF = 8;
  localparam int GROUP_BITS_DEF = 4096;

  localparam int BLK_W      = 16;
  localparam int GIDX_IN_W  = 3;
  localparam int WIDX_IN_W  = 7;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 13;
  localparam int SUM_W      = 16;
  localparam int GIDX_MAX_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 16'd65535;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

  // Write request to the group descriptor file.
  typedef struct packed {
    logic                  load;
    logic                  bump;
    logic [GIDX_MAX_W-1:0] idx;
    logic [COUNT_W-1:0]    total;
    logic [COUNT_W-1:0]    count;
    logic                  valid;
  } grp_wr_t;

  // Descriptor read out of the group descriptor file.
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } grp_rd_t;

endpackage

// File: rtl/gba_req_if.sv
// Command channel of the grouped bitmap block allocator.
interface gba_req_if;
  logic                                valid;
  logic                                ready;
  gba_pkg::cmd_t                       cmd;
  logic [gba_pkg::BLK_W-1:0]           block_number;
  logic [gba_pkg::GIDX_IN_W-1:0]       group_index;
  logic [gba_pkg::WIDX_IN_W-1:0]       word_index;
  logic [gba_pkg::WORD_W-1:0]          word_data;
  logic [gba_pkg::COUNT_W-1:0]         group_total;
  logic [gba_pkg::COUNT_W-1:0]         group_free;
  logic                                group_valid;

  modport source (
    output valid, cmd, block_number, group_index, word_index, word_data,
           group_total, group_free, group_valid,
    input  ready
  );

  modport sink (
    input  valid, cmd, block_number, group_index, word_index, word_data,
           group_total, group_free, group_valid,
    output ready
  );
endinterface

// File: rtl/gba_rsp_if.sv
// Result channel of the grouped bitmap block allocator.
interface gba_rsp_if;
  logic                       valid;
  logic                       ready;
  gba_pkg::status_t           status;
  logic                       is_free;
  logic [gba_pkg::SUM_W-1:0]  total_blocks;
  logic [gba_pkg::SUM_W-1:0]  free_blocks;

  modport source (
    output valid, status, is_free, total_blocks, free_blocks,
    input  ready
  );

  modport sink (
    input  valid, status, is_free, total_blocks, free_blocks,
    output ready
  );
endinterface

// File: rtl/gba_groups.sv
// Group descriptor file: valid mark, block total and free count per group.
module gba_groups #(
  parameter int NUM_GROUPS = gba_pkg::NUM_GROUPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [gba_pkg::GIDX_MAX_W-1:0]   rd_idx,
  output gba_pkg::grp_rd_t                 rd,
  input  gba_pkg::grp_wr_t                 wr
);
  import gba_pkg::*;

  localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  logic               link_valid [NUM_GROUPS];
  logic [COUNT_W-1:0] block_total[NUM_GROUPS];
  logic [COUNT_W-1:0] free_count [NUM_GROUPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        link_valid[i]  <= 1'b0;
        block_total[i] <= '0;
        free_count[i]  <= '0;
      end
    end else if (wr.load) begin
      link_valid[wr.idx[GIDX_W-1:0]]  <= wr.valid;
      block_total[wr.idx[GIDX_W-1:0]] <= wr.total;
      free_count[wr.idx[GIDX_W-1:0]]  <= wr.count;
    end else if (wr.bump) begin
      free_count[wr.idx[GIDX_W-1:0]]  <= wr.count;
    end
  end

  assign rd.valid = link_valid[rd_idx[GIDX_W-1:0]];
  assign rd.total = block_total[rd_idx[GIDX_W-1:0]];
  assign rd.count = free_count[rd_idx[GIDX_W-1:0]];

endmodule

// File: rtl/grouped_bitmap_block_allocator.sv
// Top level of the grouped bitmap block allocator: sequencer and bitmap memory.
//
// Usage: commands arrive on the req channel and each produces exactly one
// transaction on the rsp channel. A query or free walks the chain of valid
// groups one group per cycle, subtracting each group's total from the block
// number in a single shared compare/subtract unit, then reads the bitmap word
// of the block it lands on and checks or updates it. Every command ends with a
// walk of the chain (the second for a query or free) through two saturating
// adders that sum the totals, starting from one, and the free counts, one group
// per cycle, before the result is registered. The block takes one command at
// a time: req.ready is high only while it is idle, which it reaches the cycle
// after rsp is taken. The result stays in the output register until rsp.ready
// takes it; a stalled receiver simply holds the block in that state.
// After reset a clearing pass zeroes the bitmap memory, one word per cycle,
// NUM_GROUPS*ceil(GROUP_BITS/32) words (1024 with the defaults), during which
// req.ready stays low. The group descriptors are cleared by reset at once.
module grouped_bitmap_block_allocator #(
  parameter int NUM_GROUPS = gba_pkg::NUM_GROUPS_DEF,
  parameter int GROUP_BITS = gba_pkg::GROUP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gba_req_if.sink       req,
  gba_rsp_if.source     rsp
);
  import gba_pkg::*;

  localparam int WPG       = (GROUP_BITS + 31) / 32;
  localparam int MEM_DEPTH = NUM_GROUPS * WPG;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int GIDX_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CNT_W     = $clog2(NUM_GROUPS + 1);
  localparam int OFF_W     = $clog2(GROUP_BITS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOCATE,
    S_READ,
    S_CHECK,
    S_SUM,
    S_RESP
  } state_t;

  state_t state;

  // Command held for the duration of its work.
  cmd_t              cmd;
  logic [BLK_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [GIDX_W-1:0] grp;
  logic [OFF_W-1:0]  off;
  logic [ADDR_W-1:0] clr_addr;
  logic [SUM_W-1:0]  tsum;
  logic [SUM_W-1:0]  fsum;

  // Registered result.
  status_t           resp_status;
  logic              resp_is_free;
  logic [SUM_W-1:0]  resp_total;
  logic [SUM_W-1:0]  resp_free;

  // Bitmap memory.
  logic [WORD_W-1:0] bitmap [MEM_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] loc_addr;

  // Group descriptor file.
  grp_rd_t                g_rd;
  grp_wr_t                g_wr;
  logic [GIDX_MAX_W-1:0]  g_rd_idx;

  logic              accept;
  logic              chain_end;
  logic              rem_past;
  logic              off_oob;
  logic              bit_free;
  logic [COUNT_W-1:0] count_bump;
  logic              overflow;
  logic [SUM_W:0]    t_add;
  logic [SUM_W:0]    f_add;
  logic [SUM_W-1:0]  t_sat;
  logic [SUM_W-1:0]  f_sat;
  logic              gi_ok;
  logic              wi_ok;

  gba_groups #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_groups (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (g_rd_idx),
    .rd     (g_rd),
    .wr     (g_wr)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid        = (state == S_RESP);
  assign rsp.status       = resp_status;
  assign rsp.is_free      = resp_is_free;
  assign rsp.total_blocks = resp_total;
  assign rsp.free_blocks  = resp_free;

  // The walk index reads the descriptor file while walking; the found group
  // is read while the bitmap word is checked.
  assign g_rd_idx = (state == S_CHECK) ? GIDX_MAX_W'(grp) : GIDX_MAX_W'(cnt[GIDX_W-1:0]);

  // Chain end test shared by both walks, then the steps of each walk.
  assign chain_end = (cnt == CNT_W'(NUM_GROUPS)) || !g_rd.valid;
  assign rem_past  = rem >= BLK_W'(g_rd.total);
  assign off_oob   = {1'b0, rem} >= 17'(GROUP_BITS);
  assign t_add     = {1'b0, tsum} + (SUM_W + 1)'(g_rd.total);
  assign f_add     = {1'b0, fsum} + (SUM_W + 1)'(g_rd.count);
  assign t_sat     = (t_add > {1'b0, SUM_MAX}) ? SUM_MAX : t_add[SUM_W-1:0];
  assign f_sat     = (f_add > {1'b0, SUM_MAX}) ? SUM_MAX : f_add[SUM_W-1:0];

  // Bitmap word and bit of the located block.
  assign loc_addr   = ADDR_W'(32'(grp) * WPG + 32'(off[OFF_W-1:5]));
  assign bit_free   = rd_data[off[4:0]];
  assign count_bump = (g_rd.count < COUNT_MAX) ? g_rd.count + 1'b1 : g_rd.count;
  assign overflow   = count_bump > g_rd.total;

  assign gi_ok = 32'(req.group_index) < NUM_GROUPS;
  assign wi_ok = 32'(req.word_index) < WPG;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = loc_addr;
    mem_wdata = rd_data | (WORD_W'(1) << off[4:0]);
    g_wr       = '0;
    g_wr.idx   = GIDX_MAX_W'(grp);
    g_wr.count = count_bump;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept && req.cmd == CMD_WRITE && gi_ok && wi_ok) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(32'(req.group_index) * WPG + 32'(req.word_index));
          mem_wdata = req.word_data;
        end
        if (accept && req.cmd == CMD_LOAD && gi_ok) begin
          g_wr.load  = 1'b1;
          g_wr.idx   = GIDX_MAX_W'(req.group_index);
          g_wr.total = req.group_total;
          g_wr.count = req.group_free;
          g_wr.valid = req.group_valid;
        end
      end
      S_CHECK: begin
        if (cmd == CMD_FREE && !bit_free) begin
          mem_we    = 1'b1;
          g_wr.bump = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= mem_wdata;
    end
    rd_data <= bitmap[loc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd          <= req.cmd;
            rem          <= req.block_number;
            cnt          <= '0;
            tsum         <= SUM_W'(1);
            fsum         <= '0;
            resp_status  <= ST_OK;
            resp_is_free <= 1'b0;
            if (req.cmd == CMD_QUERY || req.cmd == CMD_FREE) begin
              state <= S_LOCATE;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_LOCATE: begin
          if (chain_end) begin
            resp_status <= ST_NOT_FOUND;
            cnt         <= '0;
            state       <= S_SUM;
          end else if (rem_past) begin
            rem <= rem - BLK_W'(g_rd.total);
            cnt <= cnt + 1'b1;
          end else if (off_oob) begin
            resp_status <= ST_NOT_FOUND;
            cnt         <= '0;
            state       <= S_SUM;
          end else begin
            grp   <= cnt[GIDX_W-1:0];
            off   <= OFF_W'(rem);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          resp_is_free <= bit_free;
          if (cmd == CMD_FREE) begin
            if (bit_free) begin
              resp_status <= ST_DOUBLE_FREE;
            end else if (overflow) begin
              resp_status <= ST_OVERFLOW;
            end
          end
          cnt   <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (chain_end) begin
            resp_total <= tsum;
            resp_free  <= fsum;
            state      <= S_RESP;
          end else begin
            tsum <= t_sat;
            fsum <= f_sat;
            cnt  <= cnt + 1'b1;
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: dv/gba_result_checker.sv
// Checker for the allocator: tracks its state and compares every result.
module gba_result_checker #(
  parameter int NUM_GROUPS = gba_pkg::NUM_GROUPS_DEF,
  parameter int GROUP_BITS = gba_pkg::GROUP_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  gba_req_if   req,
  gba_rsp_if   rsp,
  output int   mismatches,
  output int   owed
);
  import gba_pkg::*;

  localparam int WORDS_PER_GRP = (GROUP_BITS + 31) / 32;
  localparam int MAP_WORDS     = NUM_GROUPS * WORDS_PER_GRP;

  typedef struct packed {
    status_t            status;
    logic               is_free;
    logic [SUM_W-1:0]   total_blocks;
    logic [SUM_W-1:0]   free_blocks;
  } alloc_result_t;

  logic [WORD_W-1:0]  free_map [MAP_WORDS];
  logic [COUNT_W-1:0] grp_total [NUM_GROUPS];
  logic [COUNT_W-1:0] grp_count [NUM_GROUPS];
  logic               grp_link [NUM_GROUPS];

  alloc_result_t expected_results[$];

  // Applies one command to the tracked state and returns the result it must produce.
  function automatic alloc_result_t allocator_outcome(
    cmd_t c, logic [BLK_W-1:0] blk, logic [GIDX_IN_W-1:0] gi, logic [WIDX_IN_W-1:0] wi,
    logic [WORD_W-1:0] wd, logic [COUNT_W-1:0] gt, logic [COUNT_W-1:0] gf, logic gv);
    alloc_result_t r;
    int unsigned   rem;
    int unsigned   off;
    int unsigned   widx;
    int unsigned   tsum;
    int unsigned   fsum;
    int            g;
    int            hit;
    bit            walking;
    logic [WORD_W-1:0] mask;
    r.status  = ST_OK;
    r.is_free = 1'b0;
    if (c == CMD_QUERY || c == CMD_FREE) begin
      rem = blk;
      hit = -1;
      off = 0;
      walking = 1'b1;
      for (g = 0; g < NUM_GROUPS && walking; g++) begin
        if (!grp_link[g]) begin
          walking = 1'b0;
        end else if (rem >= grp_total[g]) begin
          rem -= grp_total[g];
        end else begin
          walking = 1'b0;
          // A group whose total runs past its own bitmap cannot resolve those blocks.
          if (rem < GROUP_BITS) begin
            hit = g;
            off = rem;
          end
        end
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        widx = hit * WORDS_PER_GRP + off / 32;
        mask = 32'h1 << (off % 32);
        r.is_free = (free_map[widx] & mask) != '0;
        if (c == CMD_FREE) begin
          if (r.is_free) begin
            r.status = ST_DOUBLE_FREE;
          end else begin
            free_map[widx] |= mask;
            if (grp_count[hit] < COUNT_MAX) grp_count[hit] += 1'b1;
            if (grp_count[hit] > grp_total[hit]) r.status = ST_OVERFLOW;
          end
        end
      end
    end else if (c == CMD_LOAD) begin
      if (gi < NUM_GROUPS) begin
        grp_total[gi] = gt;
        grp_count[gi] = gf;
        grp_link[gi]  = gv;
      end
    end else if (gi < NUM_GROUPS && wi < WORDS_PER_GRP) begin
      free_map[gi * WORDS_PER_GRP + wi] = wd;
    end
    tsum = 1;
    fsum = 0;
    walking = 1'b1;
    for (g = 0; g < NUM_GROUPS && walking; g++) begin
      if (!grp_link[g]) begin
        walking = 1'b0;
      end else begin
        tsum += grp_total[g];
        fsum += grp_count[g];
        if (tsum > SUM_MAX) tsum = SUM_MAX;
        if (fsum > SUM_MAX) fsum = SUM_MAX;
      end
    end
    r.total_blocks = tsum[SUM_W-1:0];
    r.free_blocks  = fsum[SUM_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < MAP_WORDS; i++) free_map[i] = '0;
      for (i = 0; i < NUM_GROUPS; i++) begin
        grp_total[i] = '0;
        grp_count[i] = '0;
        grp_link[i]  = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d total %0d free %0d",
                   $time, rsp.status, rsp.total_blocks, rsp.free_blocks);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("is_free", want.is_free, rsp.is_free);
          check_field("total_blocks", want.total_blocks, rsp.total_blocks);
          check_field("free_blocks", want.free_blocks, rsp.free_blocks);
        end
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(allocator_outcome(req.cmd, req.block_number,
          req.group_index, req.word_index, req.word_data, req.group_total,
          req.group_free, req.group_valid));
      end
    end
    owed <= expected_results.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  import gba_pkg::*;

  localparam int NG           = NUM_GROUPS_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int REBUILD_EVERY = 64;
  localparam int HOLD_AT      = 200;
  localparam int DRAIN_AT     = 400;
  localparam int CALM_AT      = 600;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 40;

  typedef enum logic [1:0] {
    PH_BUSY,
    PH_HOLD,
    PH_CALM
  } run_phase_t;

  logic clk = 1'b0;
  logic rst;
  run_phase_t phase = PH_BUSY;
  int cycles = 0;
  int fails;
  int owed;

  // What the stimulus has loaded into the descriptors, so that block numbers can be
  // aimed inside the chain. This steers stimulus only; the checker tracks the real state.
  logic [COUNT_W-1:0] shadow_total [NG];
  logic               shadow_valid [NG];

  gba_req_if req ();
  gba_rsp_if rsp ();

  grouped_bitmap_block_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  gba_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (fails),
    .owed       (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sum of totals over the leading valid groups, as the stimulus set them up.
  function automatic int chain_span();
    int s;
    int g;
    bit open;
    s = 0;
    open = 1'b1;
    for (g = 0; g < NG; g++) begin
      if (open) begin
        if (!shadow_valid[g]) open = 1'b0;
        else s += shadow_total[g];
      end
    end
    return s;
  endfunction

  // Bitmap words lean toward all-free and all-allocated so that both free and
  // double free outcomes stay common.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one command and returns at the edge where the block takes it. Now and
  // then the valid line drops for a short burst first, so that gaps land in every
  // stage of the block's sequencer.
  task automatic issue(cmd_t c, logic [BLK_W-1:0] blk, logic [GIDX_IN_W-1:0] gi,
                       logic [WIDX_IN_W-1:0] wi, logic [WORD_W-1:0] wd,
                       logic [COUNT_W-1:0] gt, logic [COUNT_W-1:0] gf, logic gv);
    if (phase != PH_CALM && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= c;
    req.block_number <= blk;
    req.group_index  <= gi;
    req.word_index   <= wi;
    req.word_data    <= wd;
    req.group_total  <= gt;
    req.group_free   <= gf;
    req.group_valid  <= gv;
    if (c == CMD_LOAD) begin
      shadow_total[gi] = gt;
      shadow_valid[gi] = gv;
    end
    do @(posedge clk); while (!req.ready);
  endtask

  // Result side: random stall bursts, one long hold-off so that the block sits on a
  // finished result and refuses new commands, and no stalls at all in the calm tail.
  initial begin : rsp_side
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (phase == PH_HOLD && !held) begin
        rsp.ready <= 1'b0;
        stall_left = LONG_HOLD;
        held = 1'b1;
      end else if (phase != PH_CALM && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    int g;
    int pick;
    int chain_len;
    int span;
    int hi;
    logic [COUNT_W-1:0] tot;
    logic [COUNT_W-1:0] fr;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.cmd          <= CMD_QUERY;
    req.block_number <= '0;
    req.group_index  <= '0;
    req.word_index   <= '0;
    req.word_data    <= '0;
    req.group_total  <= '0;
    req.group_free   <= '0;
    req.group_valid  <= 1'b0;
    for (g = 0; g < NG; g++) begin
      shadow_total[g] = '0;
      shadow_valid[g] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block clears its bitmap after reset, so the first command
    // simply waits on req.ready. An empty chain resolves nothing.
    issue(CMD_QUERY, 16'd0, 3'd0, 7'd0, '0, '0, '0, 1'b0);
    // Chain: a full-size group, a group whose total runs past its bitmap and whose
    // free count sits one below the counter ceiling, a tiny group that is already
    // full, a zero-sized group, then an invalid group that ends the chain. The
    // group after the end must not be counted.
    issue(CMD_LOAD, '0, 3'd0, '0, '0, 13'd4096, 13'd0, 1'b1);
    issue(CMD_LOAD, '0, 3'd1, '0, '0, 13'd8191, 13'd8190, 1'b1);
    issue(CMD_LOAD, '0, 3'd2, '0, '0, 13'd2, 13'd2, 1'b1);
    issue(CMD_LOAD, '0, 3'd3, '0, '0, 13'd0, 13'd8191, 1'b1);
    issue(CMD_LOAD, '0, 3'd4, '0, '0, 13'd0, 13'd0, 1'b0);
    issue(CMD_LOAD, '0, 3'd5, '0, '0, 13'd100, 13'd7, 1'b1);
    issue(CMD_WRITE, '0, 3'd0, 7'd127, 32'h8000_0001, '0, '0, 1'b0);
    issue(CMD_WRITE, '0, 3'd7, 7'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
    issue(CMD_WRITE, '0, 3'd2, 7'd0, 32'h0000_0000, '0, '0, 1'b0);
    issue(CMD_QUERY, 16'd0, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_QUERY, 16'd4064, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_QUERY, 16'd4095, '0, '0, '0, '0, '0, 1'b0);
    // Free, then free the same block again.
    issue(CMD_FREE, 16'd1, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_FREE, 16'd1, '0, '0, '0, '0, '0, 1'b0);
    // The second group's count reaches the ceiling and then saturates there.
    issue(CMD_FREE, 16'd4101, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_FREE, 16'd4102, '0, '0, '0, '0, '0, 1'b0);
    // Inside the second group's total but past its bitmap.
    issue(CMD_FREE, 16'd9096, '0, '0, '0, '0, '0, 1'b0);
    // The full tiny group: each free pushes its count past the total.
    issue(CMD_FREE, 16'd12287, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_FREE, 16'd12288, '0, '0, '0, '0, '0, 1'b0);
    // Beyond the end of the chain, and the largest block number.
    issue(CMD_QUERY, 16'd12289, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_QUERY, 16'hFFFF, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_WRITE, '0, 3'd1, 7'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
    issue(CMD_FREE, 16'd4096, '0, '0, '0, '0, '0, 1'b0);
    issue(CMD_QUERY, 16'd4127, '0, '0, '0, '0, '0, 1'b0);

    // Random part. The chain is rebuilt at intervals so that frees keep finding
    // allocated blocks; most commands aim inside the chain, a few are pure noise.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        phase <= PH_HOLD;
      end else if (n == HOLD_AT + 8) begin
        phase <= PH_BUSY;
      end else if (n == CALM_AT) begin
        phase <= PH_CALM;
      end
      if (n == DRAIN_AT) begin
        // Sender pause: let every outstanding result come back first.
        req.valid <= 1'b0;
        do @(posedge clk); while (owed != 0);
      end

      if (n % REBUILD_EVERY == 0) begin
        chain_len = $urandom_range(1, NG);
        for (g = 0; g < NG && g <= chain_len; g++) begin
          case ($urandom_range(0, 15))
            0:       tot = '0;
            1, 2:    tot = COUNT_W'($urandom_range(4097, 8191));
            default: tot = COUNT_W'($urandom_range(1, 1200));
          endcase
          if ($urandom_range(0, 3) == 0) fr = COUNT_W'($urandom);
          else fr = (tot > 3) ? tot - COUNT_W'($urandom_range(0, 3)) : tot;
          issue(CMD_LOAD, BLK_W'($urandom), GIDX_IN_W'(g), WIDX_IN_W'($urandom),
                $urandom, tot, fr, g < chain_len);
        end
        repeat (6) begin
          g = $urandom_range(0, NG - 1);
          hi = (shadow_total[g] == 0) ? 0 : (shadow_total[g] - 1) / 32;
          if (hi > 127) hi = 127;
          issue(CMD_WRITE, BLK_W'($urandom), GIDX_IN_W'(g),
                WIDX_IN_W'($urandom_range(0, hi)), pick_word(),
                COUNT_W'($urandom), COUNT_W'($urandom), 1'($urandom));
        end
      end

      pick = $urandom_range(0, 99);
      span = chain_span();
      if (pick < 70) begin
        hi = (span == 0 || $urandom_range(0, 9) == 0) ? 65535 : span - 1;
        issue($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, BLK_W'($urandom_range(0, hi)),
              GIDX_IN_W'($urandom), WIDX_IN_W'($urandom), $urandom,
              COUNT_W'($urandom), COUNT_W'($urandom), 1'($urandom));
      end else if (pick < 82) begin
        g = $urandom_range(0, NG - 1);
        hi = (shadow_total[g] == 0) ? 0 : (shadow_total[g] - 1) / 32;
        if (hi > 127) hi = 127;
        issue(CMD_WRITE, BLK_W'($urandom), GIDX_IN_W'(g),
              WIDX_IN_W'($urandom_range(0, hi)), pick_word(),
              COUNT_W'($urandom), COUNT_W'($urandom), 1'($urandom));
      end else if (pick < 87) begin
        issue(CMD_LOAD, BLK_W'($urandom), GIDX_IN_W'($urandom), WIDX_IN_W'($urandom),
              $urandom, COUNT_W'($urandom), COUNT_W'($urandom),
              $urandom_range(0, 3) != 0);
      end else begin
        issue(cmd_t'($urandom_range(int'(CMD_QUERY), int'(CMD_WRITE))), BLK_W'($urandom),
              GIDX_IN_W'($urandom), WIDX_IN_W'($urandom), $urandom,
              COUNT_W'($urandom), COUNT_W'($urandom), 1'($urandom));
      end
    end
    req.valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
